FILE: rtl/percentile_selector_macros.svh
// Assertion macros for the percentile selector.
// Define ASSERT_OFF to compile the checks out.
`ifndef PERCENTILE_SELECTOR_MACROS_SVH
`define PERCENTILE_SELECTOR_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/pctsel_pkg.sv
// Shared constants and controller/datapath interface types for the percentile selector.
// No dependencies.
`default_nettype none

package pctsel_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int SAMPLE_W       = 32;
    localparam int FRAC_W         = 17;
    localparam int FRAC_BITS      = 16;
    localparam int FRACTION_RESET = 32768;
    localparam int ROUND_HALF     = 32768;

    typedef struct packed {
        logic load;
        logic drop;
        logic rd_prev;
        logic shift_wr;
        logic place_wr;
        logic mul;
        logic pos;
        logic rd_lo;
        logic rd_hi;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic pos_zero;
        logic greater;
        logic fin;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/pctsel_dp.sv
// Datapath: sorted sample memory, insertion pointer, percentile position math, output regs.
// Depends on pctsel_pkg.
`default_nettype none

module pctsel_dp
    import pctsel_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       final_item,
    input  wire logic                       cfg_we,
    input  wire logic [FRAC_W-1:0]          cfg_data,
    input  wire cmd_t                       cmd,
    output status_t                         sts,
    output logic signed [SAMPLE_W-1:0]      percentile_value,
    output logic                            overflowed,
    output logic                            result_valid
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = FRAC_W + CW;

    logic [SAMPLE_W-1:0] mem [CAPACITY];

    logic [FRAC_W-1:0]          fraction_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic                       dropped_reg, dropped_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       fin_reg;
    logic [CW-1:0]              pos_reg, pos_next;
    logic [PW-1:0]              prod_reg;
    logic [CW-1:0]              lo_reg, hi_reg;
    logic                       whole_reg;
    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic signed [SAMPLE_W-1:0] value_reg, value_next;
    logic                       ovf_reg;
    logic                       valid_reg;

    logic [AW-1:0]   rd_addr;
    logic [CW+1:0]   prod_hi;
    logic [PW:0]     rnd_sum;
    logic [CW+1:0]   rnd_hi;
    logic [CW-1:0]   lo_c, hi_c, idx_c;
    logic            whole_c;
    logic [SAMPLE_W:0] pair_sum;

    function automatic logic [CW-1:0] clamp_pos(input logic [CW+1:0] p,
                                                 input logic [CW-1:0] n);
        logic [CW-1:0] r;
        if (p == '0)
            r = CW'(1);
        else if (p > {2'b00, n})
            r = n;
        else
            r = p[CW-1:0];
        return r;
    endfunction

    assign sts.full     = (count_reg == CW'(CAPACITY));
    assign sts.pos_zero = (pos_reg == '0);
    assign sts.greater  = (rdata_reg > sample_reg);
    assign sts.fin      = fin_reg;

    // position math on the registered product
    assign prod_hi = {1'b0, prod_reg[PW-1:FRAC_BITS]};
    assign rnd_sum = {1'b0, prod_reg} + (PW+1)'(ROUND_HALF);
    assign rnd_hi  = rnd_sum[PW:FRAC_BITS];
    assign whole_c = (prod_reg[FRAC_BITS-1:0] == '0);
    assign lo_c    = clamp_pos(prod_hi, count_reg);
    assign hi_c    = (lo_c < count_reg) ? lo_c + CW'(1) : count_reg;
    assign idx_c   = (count_reg == CW'(1)) ? CW'(1) : clamp_pos(rnd_hi, count_reg);

    always_comb
    begin
        if (cmd.rd_prev)
            rd_addr = AW'(pos_reg - CW'(1));
        else if (cmd.rd_lo)
            rd_addr = AW'(lo_reg - CW'(1));
        else
            rd_addr = AW'(hi_reg - CW'(1));
    end

    assign pair_sum = {a_reg[SAMPLE_W-1], a_reg} + {rdata_reg[SAMPLE_W-1], rdata_reg};

    always_comb
    begin
        count_next = count_reg;
        dropped_next = dropped_reg;
        pos_next = pos_reg;
        if (cmd.place_wr)
            count_next = count_reg + CW'(1);
        if (cmd.drop)
            dropped_next = 1'b1;
        if (cmd.emit)
        begin
            count_next = '0;
            dropped_next = 1'b0;
        end
        if (cmd.load)
            pos_next = count_reg;
        else if (cmd.shift_wr)
            pos_next = pos_reg - CW'(1);
        if (count_reg == '0)
            value_next = '0;
        else if (whole_reg)
            value_next = pair_sum[SAMPLE_W:1];
        else
            value_next = a_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fraction_reg <= FRAC_W'(FRACTION_RESET);
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            pos_reg      <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                fraction_reg <= cfg_data;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            pos_reg     <= pos_next;
            valid_reg   <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
            fin_reg    <= final_item;
        end
        if (cmd.mul)
            prod_reg <= PW'(fraction_reg * count_reg);
        if (cmd.pos)
        begin
            whole_reg <= whole_c;
            lo_reg    <= whole_c ? lo_c : idx_c;
            hi_reg    <= whole_c ? hi_c : idx_c;
        end
        if (cmd.rd_hi)
            a_reg <= rdata_reg;
        if (cmd.emit)
        begin
            value_reg <= value_next;
            ovf_reg   <= dropped_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
        if (cmd.shift_wr)
            mem[pos_reg[AW-1:0]] <= rdata_reg;
        else if (cmd.place_wr)
            mem[pos_reg[AW-1:0]] <= sample_reg;
    end

    assign percentile_value = value_reg;
    assign overflowed       = ovf_reg;
    assign result_valid     = valid_reg;

endmodule

`default_nettype wire

FILE: rtl/pctsel_ctrl.sv
// Controller FSM: sequences insertion, drop and percentile readout.
// Depends on pctsel_pkg.
`default_nettype none

module pctsel_ctrl
    import pctsel_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire status_t sts,
    output cmd_t         cmd,
    output logic         busy
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_INS_RD  = 8'b0000_0010,
        S_INS_CMP = 8'b0000_0100,
        S_MUL     = 8'b0000_1000,
        S_POS     = 8'b0001_0000,
        S_RD_A    = 8'b0010_0000,
        S_RD_B    = 8'b0100_0000,
        S_OUT     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    state_t done_state;

    assign done_state = sts.fin ? S_MUL : S_IDLE;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                if (sts.full)
                begin
                    cmd.drop = 1'b1;
                    state_next = done_state;
                end
                else if (sts.pos_zero)
                begin
                    cmd.place_wr = 1'b1;
                    state_next = done_state;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (sts.greater)
                begin
                    cmd.shift_wr = 1'b1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    cmd.place_wr = 1'b1;
                    state_next = done_state;
                end
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = S_POS;
            end
            S_POS:
            begin
                cmd.pos = 1'b1;
                state_next = S_RD_A;
            end
            S_RD_A:
            begin
                cmd.rd_lo = 1'b1;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.rd_hi = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.emit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/percentile_selector.sv
// Percentile selector top level: controller plus datapath, with port checks.
// Depends on pctsel_pkg, pctsel_ctrl, pctsel_dp and percentile_selector_macros.svh.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------
//  input    | start & !busy           | sample, final_item
//  result   | result_valid (1 cycle)  | percentile_value, overflowed
//  config   | cfg_valid & cfg_ready   | cfg_data (fraction, Q1.16)
//
// An item reads and shifts up each held entry that its sample moves past, then is placed
// at the bottom of the store or after one more read finds an entry not greater than it;
// a sample dropped on a full store is discarded. The final item adds multiply, position,
// two memory reads and the output register; one entry is moved per read/write pair.
// Reset leaves the set empty and the fraction at one half; memory contents are not cleared.
// Results are not flow-controlled: result_valid is high for exactly one cycle per set.
`default_nettype none

`include "percentile_selector_macros.svh"

module percentile_selector
    import pctsel_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       final_item,
    output logic                            result_valid,
    output logic signed [SAMPLE_W-1:0]      percentile_value,
    output logic                            overflowed,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [FRAC_W-1:0]          cfg_data
);

    cmd_t    cmd;
    status_t sts;

    assign cfg_ready = !busy;

    pctsel_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    pctsel_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample           (sample),
        .final_item       (final_item),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .sts              (sts),
        .percentile_value (percentile_value),
        .overflowed       (overflowed),
        .result_valid     (result_valid)
    );

    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPLY(a_result_idle, clk, rst_n, result_valid, !busy)
    `ASSERT_NEXT(a_result_single, clk, rst_n, result_valid, !result_valid)

endmodule

`default_nettype wire
